// ===== hw/rtl/sdf_pkg.sv =====
// ============================================================================
// sdf_pkg: shared types and constants of the signed decimal field formatter
// Field limits, ASCII codes, controller states, command/status bundles and
// the double-dabble step used by the binary to BCD converter.
// ============================================================================
package sdf_pkg;

	// field limits and widths
	localparam int MAX_FIELD  = 64;
	localparam int VALUE_W    = 32;
	localparam int WIDTH_W    = 7;
	localparam int PREC_W     = 6;
	localparam int CHAR_W     = 8;
	localparam int DIGITS     = 10;
	localparam int DIGIT_W    = 4;
	localparam int ND_W       = 4;
	localparam int CNT_W      = 7;

	// binary to BCD conversion: bits shifted in per cycle
	localparam int CONV_BITS  = 4;
	localparam int CONV_STEPS = VALUE_W / CONV_BITS;
	localparam int STEP_W     = $clog2(CONV_STEPS);

	// ASCII codes
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef digit_t [DIGITS-1:0] bcd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_COUNT,
		ST_PLAN,
		ST_BOUND,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic conv;
		logic count;
		logic plan;
		logic bound;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic conv_last;
		logic empty;
		logic emit_last;
		logic out_free;
	} sts_t;

	// one double-dabble step: adjust every digit, then shift in one bit
	function automatic bcd_t dabble(input bcd_t b, input logic bit_in);
		bcd_t                       adj;
		logic [DIGITS*DIGIT_W-1:0]  flat;
		for (int i = 0; i < DIGITS; i++) begin
			adj[i] = (b[i] >= 4'd5) ? b[i] + 4'd3 : b[i];
		end
		flat = adj;
		return bcd_t'({flat[DIGITS*DIGIT_W-2:0], bit_in});
	endfunction

endpackage

// ===== hw/rtl/sdf_channels.sv =====
// ============================================================================
// sdf_channels: request channels of the signed decimal field formatter
// sdf_item_if carries one integer with its conversion spec; sdf_char_if
// carries one character of the formatted field.
// ============================================================================
interface sdf_item_if;
	logic                                valid;
	logic                                ready;
	logic signed [sdf_pkg::VALUE_W-1:0]  value;
	logic [sdf_pkg::WIDTH_W-1:0]         field_width;
	logic [sdf_pkg::PREC_W-1:0]          precision;
	logic                                precision_given;
	logic                                left_justify;
	logic                                zero_fill;
	logic                                force_plus;
	logic                                space_sign;

	modport source (
		output valid, value, field_width, precision, precision_given,
		       left_justify, zero_fill, force_plus, space_sign,
		input  ready
	);
	modport sink (
		input  valid, value, field_width, precision, precision_given,
		       left_justify, zero_fill, force_plus, space_sign,
		output ready
	);
endinterface

interface sdf_char_if;
	logic                         valid;
	logic                         ready;
	logic [sdf_pkg::CHAR_W-1:0]   out_char;
	logic                         last_char;

	modport source (output valid, out_char, last_char, input ready);
	modport sink (input valid, out_char, last_char, output ready);
endinterface

// ===== hw/rtl/sdf_ctrl.sv =====
// ============================================================================
// sdf_ctrl: sequencing controller
// Walks each request through conversion, digit count, layout and character
// emission, issuing one command bundle per cycle to the datapath.
// ============================================================================
module sdf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sdf_pkg::sts_t  sts,
	output sdf_pkg::cmd_t  cmd
);

	sdf_pkg::state_t state_q;
	sdf_pkg::state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sdf_pkg::ST_IDLE: begin
				if (in_valid) state_d = sdf_pkg::ST_CONV;
			end
			sdf_pkg::ST_CONV: begin
				if (sts.conv_last) state_d = sdf_pkg::ST_COUNT;
			end
			sdf_pkg::ST_COUNT: state_d = sdf_pkg::ST_PLAN;
			sdf_pkg::ST_PLAN:  state_d = sdf_pkg::ST_BOUND;
			sdf_pkg::ST_BOUND: state_d = sdf_pkg::ST_EMIT;
			sdf_pkg::ST_EMIT: begin
				if (sts.empty || (sts.out_free && sts.emit_last)) begin
					state_d = sdf_pkg::ST_IDLE;
				end
			end
			default: state_d = sdf_pkg::ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			sdf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			sdf_pkg::ST_CONV:  cmd.conv  = 1'b1;
			sdf_pkg::ST_COUNT: cmd.count = 1'b1;
			sdf_pkg::ST_PLAN:  cmd.plan  = 1'b1;
			sdf_pkg::ST_BOUND: cmd.bound = 1'b1;
			sdf_pkg::ST_EMIT:  cmd.emit  = sts.out_free && !sts.empty;
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

// ===== hw/rtl/sdf_dp.sv =====
// ============================================================================
// sdf_dp: formatter datapath
// Holds the spec, converts the magnitude to BCD four bits a cycle, counts
// digits, lays out the field segments and drives the character register.
// ============================================================================
module sdf_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sdf_pkg::cmd_t                       cmd,
	output sdf_pkg::sts_t                       sts,
	input  logic signed [sdf_pkg::VALUE_W-1:0]  value,
	input  logic [sdf_pkg::WIDTH_W-1:0]         field_width,
	input  logic [sdf_pkg::PREC_W-1:0]          precision,
	input  logic                                precision_given,
	input  logic                                left_justify,
	input  logic                                zero_fill,
	input  logic                                force_plus,
	input  logic                                space_sign,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sdf_pkg::CHAR_W-1:0]          out_char,
	output logic                                last_char
);

	localparam int CW = sdf_pkg::CNT_W;

	// spec registers
	logic [sdf_pkg::VALUE_W-1:0] bin_q;
	logic [CW-1:0]               width_q;
	logic [sdf_pkg::PREC_W-1:0]  prec_q;
	logic                        has_prec_q;
	logic                        left_q;
	logic                        zfill_q;
	logic                        zero_supp_q;
	logic                        has_sign_q;
	logic [sdf_pkg::CHAR_W-1:0]  sign_ch_q;

	// conversion and layout registers
	sdf_pkg::bcd_t               bcd_q;
	logic [sdf_pkg::STEP_W-1:0]  iter_q;
	logic [sdf_pkg::ND_W-1:0]    nd_q;
	logic [CW-1:0]               zeros_q;
	logic [CW-1:0]               pad_q;
	logic [CW-1:0]               b1_q;
	logic [CW-1:0]               b2_q;
	logic [CW-1:0]               b3_q;
	logic [CW-1:0]               b4_q;
	logic [CW-1:0]               n_q;
	logic [CW-1:0]               pos_q;

	// output register
	logic                        out_valid_q;
	logic [sdf_pkg::CHAR_W-1:0]  out_char_q;
	logic                        last_q;

	// combinational values
	logic [sdf_pkg::VALUE_W-1:0] mag_c;
	logic [CW-1:0]               width_c;
	logic [sdf_pkg::PREC_W-1:0]  prec_c;
	sdf_pkg::bcd_t               bcd_c;
	logic [sdf_pkg::ND_W-1:0]    nd_c;
	logic [CW-1:0]               nd7_c;
	logic [CW-1:0]               prec7_c;
	logic [CW-1:0]               zeros_c;
	logic [CW-1:0]               body_c;
	logic [CW-1:0]               pad_c;
	logic [CW-1:0]               b1_c;
	logic [CW-1:0]               b2_c;
	logic [CW-1:0]               b3_c;
	logic [CW-1:0]               b4_c;
	logic [CW-1:0]               didx_c;
	logic [sdf_pkg::CHAR_W-1:0]  char_c;
	logic                        out_free_c;

	// magnitude and saturated spec at load
	always_comb begin
		mag_c   = value[sdf_pkg::VALUE_W-1] ? (32'd0 - value) : value;
		width_c = (field_width > CW'(sdf_pkg::MAX_FIELD)) ?
		          CW'(sdf_pkg::MAX_FIELD) : field_width;
		prec_c  = (CW'(precision) > CW'(sdf_pkg::MAX_FIELD - 1)) ?
		          sdf_pkg::PREC_W'(sdf_pkg::MAX_FIELD - 1) : precision;
	end

	// shift four magnitude bits into the BCD digits
	always_comb begin
		bcd_c = bcd_q;
		for (int k = 0; k < sdf_pkg::CONV_BITS; k++) begin
			bcd_c = sdf_pkg::dabble(bcd_c, bin_q[sdf_pkg::VALUE_W-1-k]);
		end
	end

	// digit count: highest nonzero digit, at least one unless suppressed
	always_comb begin
		nd_c = sdf_pkg::ND_W'(1);
		for (int i = 1; i < sdf_pkg::DIGITS; i++) begin
			if (bcd_q[i] != '0) nd_c = sdf_pkg::ND_W'(i + 1);
		end
		if (zero_supp_q) nd_c = '0;
	end

	// precision zeros, zero fill and space padding
	always_comb begin
		nd7_c   = CW'(nd_q);
		prec7_c = CW'(prec_q);
		zeros_c = (has_prec_q && (prec7_c > nd7_c)) ? prec7_c - nd7_c : '0;
		body_c  = CW'(has_sign_q) + zeros_c + nd7_c;
		if (!has_prec_q && zfill_q && !left_q && (width_q > body_c)) begin
			zeros_c = zeros_c + (width_q - body_c);
			body_c  = width_q;
		end
		pad_c = (width_q > body_c) ? width_q - body_c : '0;
	end

	// segment boundaries
	always_comb begin
		b1_c = left_q ? '0 : pad_q;
		b2_c = b1_c + CW'(has_sign_q);
		b3_c = b2_c + zeros_q;
		b4_c = b3_c + CW'(nd_q);
	end

	// pick the character at the current position
	always_comb begin
		didx_c = b4_q - pos_q - CW'(1);
		if (pos_q < b1_q) begin
			char_c = sdf_pkg::CH_SPACE;
		end else if (pos_q < b2_q) begin
			char_c = sign_ch_q;
		end else if (pos_q < b3_q) begin
			char_c = sdf_pkg::CH_ZERO;
		end else if (pos_q < b4_q) begin
			char_c = sdf_pkg::CH_ZERO |
			         sdf_pkg::CHAR_W'(bcd_q[didx_c[sdf_pkg::ND_W-1:0]]);
		end else begin
			char_c = sdf_pkg::CH_SPACE;
		end
	end

	// load the spec
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q       <= mag_c;
			width_q     <= width_c;
			prec_q      <= prec_c;
			has_prec_q  <= precision_given;
			left_q      <= left_justify;
			zfill_q     <= zero_fill;
			zero_supp_q <= precision_given && (prec_c == '0) && (value == '0);
			has_sign_q  <= value[sdf_pkg::VALUE_W-1] || force_plus || space_sign;
			if (value[sdf_pkg::VALUE_W-1]) begin
				sign_ch_q <= sdf_pkg::CH_MINUS;
			end else if (force_plus) begin
				sign_ch_q <= sdf_pkg::CH_PLUS;
			end else begin
				sign_ch_q <= sdf_pkg::CH_SPACE;
			end
		end else if (cmd.conv) begin
			bin_q <= bin_q << sdf_pkg::CONV_BITS;
		end
	end

	// conversion, count and layout
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bcd_q  <= '0;
			iter_q <= '0;
		end else if (cmd.conv) begin
			bcd_q  <= bcd_c;
			iter_q <= iter_q + sdf_pkg::STEP_W'(1);
		end
		if (cmd.count) nd_q <= nd_c;
		if (cmd.plan) begin
			zeros_q <= zeros_c;
			pad_q   <= pad_c;
		end
		if (cmd.bound) begin
			b1_q  <= b1_c;
			b2_q  <= b2_c;
			b3_q  <= b3_c;
			b4_q  <= b4_c;
			n_q   <= b4_c + (left_q ? pad_q : '0);
			pos_q <= '0;
		end else if (cmd.emit) begin
			pos_q <= pos_q + CW'(1);
		end
	end

	// output register: hold until taken, advance on emit
	assign out_free_c = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_char_q <= char_c;
			last_q     <= (pos_q == n_q - CW'(1));
		end
	end

	// status to the controller
	always_comb begin
		sts.conv_last = (iter_q == sdf_pkg::STEP_W'(sdf_pkg::CONV_STEPS - 1));
		sts.empty     = (n_q == '0);
		sts.emit_last = (pos_q == n_q - CW'(1));
		sts.out_free  = out_free_c;
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign last_char = last_q;

endmodule

// ===== hw/rtl/signed_decimal_field_formatter.sv =====
// ============================================================================
// signed_decimal_field_formatter: printf "%d" field formatter
// Takes one signed 32-bit integer with its conversion spec and emits the
// formatted field one ASCII character per request, last one marked.
// ============================================================================
//
//  channel  role   carries
//  -------  -----  -----------------------------------------------------
//  item     sink   value, field_width, precision and flags, one per field
//  chr      source out_char, last_char; one request per field character
//
//  A field goes through these steps in order: accepting the item, the
//  binary to BCD conversion (four bits a cycle through chained
//  double-dabble steps), digit count and layout, then one character per
//  cycle out of the output register while chr is not stalled. An empty
//  field ends with no request. A stalled chr holds emission; the next item
//  is taken once the last character sits in the output register. Reset
//  returns the controller to idle and empties the output register.
//
module signed_decimal_field_formatter (
	input logic          clk,
	input logic          arst_n,
	sdf_item_if.sink     item,
	sdf_char_if.source   chr
);

	sdf_pkg::cmd_t cmd;
	sdf_pkg::sts_t sts;

	// controller
	sdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	sdf_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.value           (item.value),
		.field_width     (item.field_width),
		.precision       (item.precision),
		.precision_given (item.precision_given),
		.left_justify    (item.left_justify),
		.zero_fill       (item.zero_fill),
		.force_plus      (item.force_plus),
		.space_sign      (item.space_sign),
		.out_valid       (chr.valid),
		.out_ready       (chr.ready),
		.out_char        (chr.out_char),
		.last_char       (chr.last_char)
	);

endmodule

// ===== hw/rtl/sdf_checker.sv =====
// ============================================================================
// sdf_checker: port-level checks of the signed decimal field formatter
// Watches both channels and flags broken output holds and early acceptance.
// ============================================================================
module sdf_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         item_valid,
	input logic                         item_ready,
	input logic                         chr_valid,
	input logic                         chr_ready,
	input logic [sdf_pkg::CHAR_W-1:0]   chr_out_char,
	input logic                         chr_last_char
);

	// a stalled character request holds its payload
	a_chr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		chr_valid && !chr_ready |=>
			chr_valid && $stable(chr_out_char) && $stable(chr_last_char))
		else $error("character request changed while stalled");

	// an accepted item keeps the block busy through conversion
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready ##1 !item_ready)
		else $error("item taken during conversion");

	// when idle, only the last character of a field may still wait
	a_idle_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		item_ready && chr_valid |-> chr_last_char)
		else $error("idle with a field still being emitted");

endmodule

bind signed_decimal_field_formatter sdf_checker u_sdf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item.valid),
	.item_ready    (item.ready),
	.chr_valid     (chr.valid),
	.chr_ready     (chr.ready),
	.chr_out_char  (chr.out_char),
	.chr_last_char (chr.last_char)
);
